/* hw/rtl/sst_pkg.sv */
// ----------------------------------------------------------------------------
// Scoped symbol table package
// Shared types, codes and default sizes for the scoped symbol table.
// ----------------------------------------------------------------------------
package sst_pkg;

	// Default sizes for the top-level parameters.
	localparam int LOCAL_LEVELS_DEF = 6;
	localparam int CAPACITY_DEF     = 64;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_BAD    = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;
	localparam logic [1:0] STAT_FULL = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// One stored table entry, as it sits in the memory.
	typedef struct packed {
		logic        valid;
		logic [2:0]  scope;
		logic [63:0] key;
		logic [31:0] value;
	} entry_t;

	// The request held while the table is scanned.
	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  scope;
		logic [63:0] key;
	} req_t;

	// Scan results handed from the match unit to the sequencer.
	typedef struct packed {
		logic dup;
		logic free_found;
		logic found;
		logic clr_hit;
	} match_t;

endpackage

/* hw/rtl/sst_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/sst_match.sv */
// ----------------------------------------------------------------------------
// Scoped symbol table match unit
// Compares each entry read during a scan with the held request and keeps
// the duplicate flag, the first free slot and the best lookup hit, and flags clear hits.
// ----------------------------------------------------------------------------
module sst_match #(
	parameter int LOCAL_LEVELS = sst_pkg::LOCAL_LEVELS_DEF,
	parameter int CAPACITY     = sst_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        chk,
	input  sst_pkg::req_t               req,
	input  sst_pkg::entry_t             entry,
	input  logic [$clog2(CAPACITY)-1:0] addr,
	output sst_pkg::match_t             flags,
	output logic [$clog2(CAPACITY)-1:0] free_addr,
	output logic [31:0]                 found_value
);

	localparam int         AW          = $clog2(CAPACITY);
	localparam logic [3:0] GLOBAL_CODE = 4'(LOCAL_LEVELS);

	logic          dup_q;
	logic          free_found_q;
	logic          found_q;
	logic [3:0]    rank_q;
	logic [AW-1:0] free_addr_q;
	logic [31:0]   value_q;

	logic       key_hit;
	logic       ent_glob;
	logic       req_glob;
	logic       in_range;
	logic [3:0] rank;
	logic       dup_hit;
	logic       free_hit;
	logic       take;
	logic       clr_hit;

	// Per-entry compare against the held request.
	always_comb begin
		key_hit  = entry.valid && (entry.key == req.key);
		ent_glob = ({1'b0, entry.scope} == GLOBAL_CODE);
		req_glob = ({1'b0, req.scope} == GLOBAL_CODE);
		in_range = ent_glob || (!req_glob && (entry.scope <= req.scope));
		rank     = ent_glob ? 4'd0 : ({1'b0, entry.scope} + 4'd1);
		dup_hit  = chk && (req.op == sst_pkg::OP_INSERT) && key_hit
			&& (entry.scope == req.scope);
		free_hit = chk && (req.op == sst_pkg::OP_INSERT) && !entry.valid && !free_found_q;
		take     = chk && (req.op == sst_pkg::OP_LOOKUP) && key_hit && in_range
			&& (!found_q || (rank > rank_q));
		clr_hit  = chk && (req.op == sst_pkg::OP_CLEAR) && entry.valid
			&& (req_glob || (entry.scope == req.scope));
	end

	// Accumulated flags, cleared at the start of every scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
			rank_q       <= 4'd0;
		end else if (start) begin
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			found_q      <= 1'b0;
			rank_q       <= 4'd0;
		end else begin
			if (dup_hit) begin
				dup_q <= 1'b1;
			end
			if (free_hit) begin
				free_found_q <= 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
				rank_q  <= rank;
			end
		end
	end

	// Payload of the accumulated results.
	always_ff @(posedge clk) begin
		if (free_hit) begin
			free_addr_q <= addr;
		end
		if (take) begin
			value_q <= entry.value;
		end
	end

	assign flags = '{dup: dup_q, free_found: free_found_q, found: found_q,
		clr_hit: clr_hit};
	assign free_addr   = free_addr_q;
	assign found_value = value_q;

endmodule

/* hw/rtl/scoped_symbol_table.sv */
// An accepted insert, lookup or clear beat passes the scan, drain and finish
// states before its result is loaded; a bad operation or scope code goes
// straight to finish. The next beat is taken only in idle, once the result is
// loaded; the scan reads every entry through the single read port of the memory.
// Reset: the sequencer first sweeps the memory, one entry per cycle, marking
// every entry free; no beat is accepted meanwhile.
// ----------------------------------------------------------------------------
// Scoped symbol table
// Key-to-value table with numbered local scopes and one global scope, kept
// in one entry memory that is scanned, modified and written back.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
	parameter int LOCAL_LEVELS = sst_pkg::LOCAL_LEVELS_DEF,
	parameter int CAPACITY     = sst_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [2:0]  scope,
	input  logic [63:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] result_value
);

	localparam int         AW          = $clog2(CAPACITY);
	localparam int         EW          = $bits(sst_pkg::entry_t);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
	localparam logic [3:0] GLOBAL_CODE = 4'(LOCAL_LEVELS);

	sst_pkg::state_t state_q, state_d;
	logic [AW-1:0]   cnt_q, cnt_d;
	logic            chk_s1, chk_d;
	logic [AW-1:0]   chk_addr_s1;

	sst_pkg::req_t   req_q;
	logic [31:0]     val_q;
	logic            bad_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [31:0]     result_q;

	logic            accept;
	logic            bad_in;
	logic            start;
	logic            load_out;
	logic [1:0]      status_d;
	logic [31:0]     result_d;

	logic            ram_wr_en;
	logic [AW-1:0]   ram_wr_addr;
	sst_pkg::entry_t ram_wr_data;
	logic            ram_rd_en;
	logic [EW-1:0]   ram_rd_raw;
	sst_pkg::entry_t rd_entry;

	sst_pkg::match_t m;
	logic [AW-1:0]   free_addr;
	logic [31:0]     found_value;

	assign rd_entry = sst_pkg::entry_t'(ram_rd_raw);
	assign accept   = in_valid && in_ready;
	assign bad_in   = (operation == sst_pkg::OP_BAD) || ({1'b0, scope} > GLOBAL_CODE);

	// Entry memory.
	sst_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(EW'(ram_wr_data)),
		.rd_en  (ram_rd_en),
		.rd_addr(cnt_q),
		.rd_data(ram_rd_raw)
	);

	// Entry compare and scan accumulators.
	sst_match #(
		.LOCAL_LEVELS(LOCAL_LEVELS),
		.CAPACITY    (CAPACITY)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.chk        (chk_s1),
		.req        (req_q),
		.entry      (rd_entry),
		.addr       (chk_addr_s1),
		.flags      (m),
		.free_addr  (free_addr),
		.found_value(found_value)
	);

	// Result of the held request, taken once the scan is done.
	always_comb begin
		status_d = sst_pkg::STAT_OK;
		result_d = 32'd0;
		if (bad_q) begin
			status_d = sst_pkg::STAT_BAD;
		end else begin
			case (req_q.op)
				sst_pkg::OP_INSERT: begin
					if (m.dup) begin
						status_d = sst_pkg::STAT_MISS;
					end else if (!m.free_found) begin
						status_d = sst_pkg::STAT_FULL;
					end
				end
				sst_pkg::OP_LOOKUP: begin
					if (m.found) begin
						result_d = found_value;
					end else begin
						status_d = sst_pkg::STAT_MISS;
					end
				end
				default: begin
					status_d = sst_pkg::STAT_OK;
				end
			endcase
		end
	end

	// Sequencer: next state, memory accesses and output load.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		chk_d       = 1'b0;
		start       = 1'b0;
		load_out    = 1'b0;
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = chk_addr_s1;
		ram_wr_data = rd_entry;
		ram_wr_data.valid = 1'b0;
		in_ready    = (state_q == sst_pkg::ST_IDLE);
		unique case (state_q)
			sst_pkg::ST_INIT: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = cnt_q;
				ram_wr_data = '0;
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = '0;
					state_d = sst_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			sst_pkg::ST_IDLE: begin
				if (accept) begin
					start   = 1'b1;
					cnt_d   = '0;
					state_d = bad_in ? sst_pkg::ST_FINISH : sst_pkg::ST_SCAN;
				end
			end
			sst_pkg::ST_SCAN: begin
				ram_rd_en = 1'b1;
				chk_d     = 1'b1;
				ram_wr_en = m.clr_hit;
				if (cnt_q == LAST_ADDR) begin
					cnt_d   = '0;
					state_d = sst_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			sst_pkg::ST_DRAIN: begin
				ram_wr_en = m.clr_hit;
				state_d   = sst_pkg::ST_FINISH;
			end
			sst_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = sst_pkg::ST_IDLE;
					if (!bad_q && (req_q.op == sst_pkg::OP_INSERT) && !m.dup
						&& m.free_found) begin
						ram_wr_en         = 1'b1;
						ram_wr_addr       = free_addr;
						ram_wr_data.valid = 1'b1;
						ram_wr_data.scope = req_q.scope;
						ram_wr_data.key   = req_q.key;
						ram_wr_data.value = val_q;
					end
				end
			end
			default: begin
				state_d = sst_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sst_pkg::ST_INIT;
			cnt_q       <= '0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			chk_s1  <= chk_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan address and output payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.op    <= operation;
			req_q.scope <= scope;
			req_q.key   <= key;
			val_q       <= value;
			bad_q       <= bad_in;
		end
		if (chk_d) begin
			chk_addr_s1 <= cnt_q;
		end
		if (load_out) begin
			status_q <= status_d;
			result_q <= result_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;

	// A clear write-back never lands on the entry being read in the same cycle.
	a_wb_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && (state_q == sst_pkg::ST_SCAN)) |-> (ram_wr_addr != cnt_q))
		else $error("clear write-back collides with scan read");

	// No entry is still in flight once the result is being formed.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sst_pkg::ST_FINISH) |-> !chk_s1)
		else $error("scan data pending at finish");

	// A result with a failing status carries a zero value.
	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != sst_pkg::STAT_OK)) |-> (result_value == 32'd0))
		else $error("nonzero value with failing status");

	// A new entry is written only for an insert of a new key with a free slot.
	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && (state_q == sst_pkg::ST_FINISH))
		|-> ((req_q.op == sst_pkg::OP_INSERT) && !bad_q && !m.dup && m.free_found))
		else $error("unexpected entry write at finish");

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Scoped symbol table testbench
// Drives insert, lookup, clear and bad beats into the symbol table under random
// idling and backpressure, predicts every answer with a local scoped table
// model, and compares each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          LEVELS        = sst_pkg::LOCAL_LEVELS_DEF;
	localparam int          CAPACITY      = sst_pkg::CAPACITY_DEF;
	localparam logic [2:0]  SCOPE_GLOBAL  = 3'(LEVELS);
	localparam logic [2:0]  SCOPE_INVALID = 3'd7;
	localparam int          SETTLE_CYCLES = CAPACITY + 3 + 40;
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int          POOL_SIZE     = 12;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  scope;
		logic [63:0] key;
		logic [31:0] value;
	} sym_request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
	} sym_answer_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [2:0]  scope;
	logic [63:0] key;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] result_value;

	// Predicted contents of the symbol store.
	logic        sym_valid [CAPACITY];
	logic [2:0]  sym_scope [CAPACITY];
	logic [63:0] sym_key   [CAPACITY];
	logic [31:0] sym_value [CAPACITY];

	sym_answer_t expected_answers [$];
	int unsigned beats_sent;
	int unsigned results_seen;
	int unsigned failures;
	int unsigned cycle_count;

	// Sender and receiver pacing controls.
	bit          tx_steady;
	bit          sink_steady;
	bit          hold_toggle;
	int unsigned hold_len;

	scoped_symbol_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.scope        (scope),
		.key          (key),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one request to the predicted store and returns its answer.
	function automatic sym_answer_t symtab_apply(sym_request_t rq);
		sym_answer_t ans;
		int          free_slot;
		int          best;
		int unsigned best_rank;
		int unsigned rank;
		bit          hit;
		ans.status = sst_pkg::STAT_OK;
		ans.value  = '0;
		if (rq.op == sst_pkg::OP_BAD || rq.scope > SCOPE_GLOBAL) begin
			ans.status = sst_pkg::STAT_BAD;
			return ans;
		end
		case (rq.op)
			sst_pkg::OP_INSERT: begin
				// A duplicate in the same scope wins over a full store.
				free_slot = -1;
				for (int i = 0; i < CAPACITY; i++) begin
					if (sym_valid[i]) begin
						if (sym_scope[i] == rq.scope && sym_key[i] == rq.key) begin
							ans.status = sst_pkg::STAT_MISS;
							return ans;
						end
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				if (free_slot < 0) begin
					ans.status = sst_pkg::STAT_FULL;
				end else begin
					sym_valid[free_slot] = 1'b1;
					sym_scope[free_slot] = rq.scope;
					sym_key[free_slot]   = rq.key;
					sym_value[free_slot] = rq.value;
				end
			end
			sst_pkg::OP_LOOKUP: begin
				// Innermost visible local scope ranks highest; global ranks lowest.
				best      = -1;
				best_rank = 0;
				for (int i = 0; i < CAPACITY; i++) begin
					hit  = 1'b0;
					rank = 0;
					if (sym_valid[i] && sym_key[i] == rq.key) begin
						if (sym_scope[i] == SCOPE_GLOBAL) begin
							hit = 1'b1;
						end else if (rq.scope != SCOPE_GLOBAL && sym_scope[i] <= rq.scope) begin
							hit  = 1'b1;
							rank = sym_scope[i] + 1;
						end
					end
					if (hit && (best < 0 || rank > best_rank)) begin
						best      = i;
						best_rank = rank;
					end
				end
				if (best < 0)
					ans.status = sst_pkg::STAT_MISS;
				else
					ans.value = sym_value[best];
			end
			default: begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (rq.scope == SCOPE_GLOBAL || sym_scope[i] == rq.scope)
						sym_valid[i] = 1'b0;
				end
			end
		endcase
		return ans;
	endfunction

	// Offers one beat, waits for acceptance and records the predicted answer.
	task automatic send_beat(input logic [1:0] op, input logic [2:0] sc,
			input logic [63:0] k, input logic [31:0] v);
		sym_request_t rq;
		rq.op    = op;
		rq.scope = sc;
		rq.key   = k;
		rq.value = v;
		if (!tx_steady) begin
			while ($urandom_range(99) < 30) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		operation <= op;
		scope     <= sc;
		key       <= k;
		value     <= v;
		do @(posedge clk); while (!in_ready);
		expected_answers.push_back(symtab_apply(rq));
		beats_sent++;
	endtask

	// Stops offering beats until every predicted answer has arrived.
	task automatic wait_results_done();
		in_valid <= 1'b0;
		do @(posedge clk); while (beats_sent != results_seen);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Shadowing, duplicates, bad codes and clears on a small hand-built set.
	task automatic test_directed();
		logic [63:0] k_low;
		logic [63:0] k_high;
		k_low  = 64'h0;
		k_high = 64'hffff_ffff_ffff_ffff;
		send_beat(sst_pkg::OP_LOOKUP, 3'd0, k_low, 32'h1234_5678);
		send_beat(sst_pkg::OP_INSERT, SCOPE_GLOBAL, k_low, 32'h7fff_ffff);
		send_beat(sst_pkg::OP_INSERT, 3'd0, k_low, 32'h8000_0000);
		send_beat(sst_pkg::OP_INSERT, 3'd5, k_low, 32'hffff_ffff);
		send_beat(sst_pkg::OP_INSERT, 3'd5, k_low, 32'h0000_0001);
		send_beat(sst_pkg::OP_LOOKUP, 3'd5, k_low, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, 3'd4, k_low, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, SCOPE_GLOBAL, k_low, 32'h0);
		send_beat(sst_pkg::OP_INSERT, 3'd3, k_high, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, 3'd2, k_high, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, 3'd3, k_high, 32'hffff_ffff);
		// Scope above the global code and the unused operation code.
		send_beat(sst_pkg::OP_INSERT, SCOPE_INVALID, k_high, 32'h5555_aaaa);
		send_beat(sst_pkg::OP_LOOKUP, SCOPE_INVALID, k_high, 32'h0);
		send_beat(sst_pkg::OP_CLEAR, SCOPE_INVALID, k_low, 32'h0);
		send_beat(sst_pkg::OP_BAD, 3'd0, k_low, 32'h0);
		send_beat(sst_pkg::OP_CLEAR, 3'd5, k_low, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, 3'd5, k_low, 32'h0);
		send_beat(sst_pkg::OP_CLEAR, 3'd2, k_high, 32'h0);
		send_beat(sst_pkg::OP_CLEAR, SCOPE_GLOBAL, k_low, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, 3'd0, k_low, 32'h0);
		send_beat(sst_pkg::OP_LOOKUP, SCOPE_GLOBAL, k_low, 32'h0);
		wait_results_done();
	endtask

	// Fills every slot, then probes the full store and refills a cleared scope.
	task automatic test_full_store();
		logic [63:0] base;
		logic [2:0]  first_scope;
		logic [2:0]  sc;
		base        = {$urandom, $urandom};
		first_scope = 3'($urandom_range(LEVELS));
		send_beat(sst_pkg::OP_CLEAR, SCOPE_GLOBAL, base, 32'h0);
		for (int i = 0; i < CAPACITY; i++) begin
			sc = (i == 0) ? first_scope : 3'($urandom_range(LEVELS));
			send_beat(sst_pkg::OP_INSERT, sc, base + 64'(i), pick_value());
		end
		send_beat(sst_pkg::OP_INSERT, 3'd0, base + 64'(CAPACITY), pick_value());
		send_beat(sst_pkg::OP_INSERT, first_scope, base, pick_value());
		for (int i = 0; i < 4; i++)
			send_beat(sst_pkg::OP_LOOKUP, 3'($urandom_range(LEVELS)),
				base + 64'($urandom_range(CAPACITY - 1)), 32'h0);
		send_beat(sst_pkg::OP_CLEAR, 3'd2, base, 32'h0);
		send_beat(sst_pkg::OP_INSERT, 3'd2, base + 64'(CAPACITY + 1), pick_value());
		send_beat(sst_pkg::OP_INSERT, 3'd4, base + 64'(CAPACITY + 2), pick_value());
		send_beat(sst_pkg::OP_CLEAR, SCOPE_GLOBAL, base, 32'h0);
		wait_results_done();
	endtask

	// Random mix over a small key pool so that hits, shadowing and fills occur.
	task automatic test_random_mix(input int unsigned n_items);
		logic [63:0] pool [POOL_SIZE];
		logic [1:0]  op;
		logic [2:0]  sc;
		logic [63:0] k;
		int unsigned pick;
		for (int n = 0; n < n_items; n++) begin
			if (n % 150 == 0) begin
				foreach (pool[j])
					pool[j] = {$urandom, $urandom};
			end
			pick = $urandom_range(99);
			if (pick < 47)
				op = sst_pkg::OP_INSERT;
			else if (pick < 90)
				op = sst_pkg::OP_LOOKUP;
			else if (pick < 97)
				op = sst_pkg::OP_CLEAR;
			else
				op = sst_pkg::OP_BAD;
			sc = ($urandom_range(99) < 4) ? SCOPE_INVALID : 3'($urandom_range(LEVELS));
			k  = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
				: {$urandom, $urandom};
			if ($urandom_range(199) == 0)
				wait_results_done();
			send_beat(op, sc, k, pick_value());
		end
		wait_results_done();
	endtask

	// No idling on either side for a long stretch.
	task automatic test_steady_stream(input int unsigned n_items);
		tx_steady = 1'b1;
		sink_steady <= 1'b1;
		test_random_mix(n_items);
		tx_steady = 1'b0;
		sink_steady <= 1'b0;
	endtask

	// The receiver holds off while beats keep coming, so the input stalls.
	task automatic test_output_stall();
		hold_len    <= 400;
		hold_toggle <= ~hold_toggle;
		tx_steady = 1'b1;
		for (int n = 0; n < 12; n++)
			send_beat($urandom_range(1) ? sst_pkg::OP_INSERT : sst_pkg::OP_LOOKUP,
				3'($urandom_range(LEVELS)), {60'h0, 4'($urandom)}, pick_value());
		tx_steady = 1'b0;
		wait_results_done();
	endtask

	// Receiver pacing, with an optional long hold-off counted here.
	initial begin : result_sink
		int unsigned hold_left;
		bit          seen_toggle;
		hold_left   = 0;
		seen_toggle = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen_toggle) begin
				seen_toggle = hold_toggle;
				hold_left   = hold_len;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (sink_steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 30);
			end
		end
	end

	// Compare each result beat with the oldest predicted answer.
	always @(posedge clk) begin : answer_check
		sym_answer_t exp_ans;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result beat: status %0d, value %0d", $time,
					status, $signed(result_value));
				failures++;
			end else begin
				exp_ans = expected_answers.pop_front();
				if (status !== exp_ans.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d", $time,
						exp_ans.status, status);
					failures++;
				end
				if (result_value !== exp_ans.value) begin
					$display("%0t: result_value mismatch: expected %0d, actual %0d",
						$time, $signed(exp_ans.value), $signed(result_value));
					failures++;
				end
				results_seen <= results_seen + 1;
			end
		end
	end

	// Cycle limit on the whole run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		beats_sent   = 0;
		results_seen = 0;
		failures     = 0;
		tx_steady    = 1'b0;
		sink_steady  = 1'b0;
		hold_toggle  = 1'b0;
		hold_len     = 0;
		foreach (sym_valid[i]) begin
			sym_valid[i] = 1'b0;
			sym_scope[i] = '0;
			sym_key[i]   = '0;
			sym_value[i] = '0;
		end
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		operation <= sst_pkg::OP_INSERT;
		scope     <= 3'd0;
		key       <= 64'h0;
		value     <= 32'h0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_store();
		test_random_mix(1000);
		test_steady_stream(300);
		test_output_stall();
		test_random_mix(560);

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && expected_answers.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

/* scoped_symbol_table.f */
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_match.sv
hw/rtl/scoped_symbol_table.sv
tb/sv/testbench.sv
